// ===== hw/rtl/crs_pkg.sv =====
package crs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned PATTERN_MAX_DEF = 16;

  typedef enum logic [2:0] {
    KIND_LOAD_PATTERN = 3'd0,
    KIND_LOAD_TIMING  = 3'd1,
    KIND_START        = 3'd2,
    KIND_RX_BYTE      = 3'd3,
    KIND_TICK         = 3'd4,
    KIND_TX_STATUS    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SEND    = 3'd1,
    EV_DONE    = 3'd2,
    EV_HWERR   = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_ERRRSP  = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    IDX_ZERO = 2'd0,
    IDX_CUR  = 2'd1,
    IDX_NEXT = 2'd2
  } idx_sel_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_TX    = 4'b0010,
    PH_REPLY = 4'b0100,
    PH_AFTER = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    SEQ_WAIT = 3'b001,
    SEQ_READ = 3'b010,
    SEQ_EXEC = 3'b100
  } seq_e;

  typedef struct packed {
    logic     capture;
    logic     read;
    logic     wr_pattern;
    logic     wr_entry;
    logic     entry_zero;
    logic     entry_inc;
    logic     entry_clear;
    logic     rx_seen;
    logic     rx_match;
    logic     tick;
    logic     clr_elapsed;
    logic     out_load;
    event_e   ev;
    idx_sel_e idx_sel;
  } crs_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  tx_ok;
    logic  len_zero;
    logic  matched;
    logic  any_rx;
    logic  rx_full;
    logic  tmo_hit;
    logic  dly_hit;
    logic  first_in;
    logic  next_in;
  } crs_status_t;

endpackage

// ===== hw/rtl/crs_datapath.sv =====
module crs_datapath #(
  parameter int unsigned TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PATTERN_MAX = crs_pkg::PATTERN_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic [2:0]          kind_i,
  input  logic [3:0]          entry_i,
  input  logic [3:0]          byte_position_i,
  input  logic [7:0]          data_byte_i,
  input  logic [4:0]          pattern_length_i,
  input  logic [15:0]         response_timeout_ms_i,
  input  logic [15:0]         after_delay_ms_i,
  input  logic                transmit_ok_i,
  input  crs_pkg::crs_cmd_t   cmd_i,
  output crs_pkg::crs_status_t status_o,
  output logic [2:0]          event_res_o,
  output logic [3:0]          entry_index_o
);
  import crs_pkg::*;

  localparam int unsigned PAT_DEPTH = TABLE_DEPTH * PATTERN_MAX;
  localparam int unsigned EA_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PA_W = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int unsigned PW_W = PA_W + 1;
  localparam int unsigned CE_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MP_W = $clog2(PATTERN_MAX + 1);

  // captured transaction
  logic [2:0]  kind_q;
  logic [3:0]  entry_q;
  logic [3:0]  pos_q;
  logic [7:0]  byte_q;
  logic [4:0]  plen_q;
  logic [15:0] tmo_q;
  logic [15:0] dly_q;
  logic        ok_q;

  // sequence state
  logic [4:0]      table_length_q;
  logic [CE_W-1:0] current_entry_q;
  logic [15:0]     elapsed_q;
  logic [MP_W-1:0] match_q;
  logic            matched_q;
  logic            any_q;

  // stores
  logic [7:0]      pat_mem [PAT_DEPTH];
  logic [MP_W-1:0] len_mem [TABLE_DEPTH];
  logic [15:0]     tmo_mem [TABLE_DEPTH];
  logic [15:0]     dly_mem [TABLE_DEPTH];

  logic [7:0]      pat_cur_q;
  logic [7:0]      pat_first_q;
  logic [MP_W-1:0] len_rd_q;
  logic [15:0]     tmo_rd_q;
  logic [15:0]     dly_rd_q;

  logic [2:0] ev_q;
  logic [3:0] idx_q;

  logic            load_ent_ok;
  logic            load_pos_ok;
  logic [MP_W-1:0] plen_sat;
  logic [PW_W-1:0] wr_pat_w;
  logic [PA_W-1:0] wr_pat_addr;
  logic [EA_W-1:0] wr_ent_addr;
  logic [EA_W-1:0] ent_rd;
  logic [MP_W-1:0] mp_rd;
  logic [PW_W-1:0] base_w;
  logic [PW_W-1:0] cur_w;
  logic [MP_W-1:0] rx_next;
  logic [15:0]     el_inc;
  logic [CE_W-1:0] used_len;
  logic [CE_W-1:0] entry_next;

  assign load_ent_ok = 32'(entry_q) < TABLE_DEPTH;
  assign load_pos_ok = 32'(pos_q) < PATTERN_MAX;
  assign plen_sat    = (32'(plen_q) > PATTERN_MAX) ? MP_W'(PATTERN_MAX) : MP_W'(plen_q);
  assign wr_pat_w    = PW_W'(PW_W'(entry_q) * PW_W'(PATTERN_MAX)) + PW_W'(pos_q);
  assign wr_pat_addr = wr_pat_w[PA_W-1:0];
  assign wr_ent_addr = EA_W'(entry_q);

  assign ent_rd = (32'(current_entry_q) < TABLE_DEPTH) ? EA_W'(current_entry_q) : '0;
  assign mp_rd  = (32'(match_q) < PATTERN_MAX) ? match_q : '0;
  assign base_w = PW_W'(PW_W'(ent_rd) * PW_W'(PATTERN_MAX));
  assign cur_w  = base_w + PW_W'(mp_rd);

  // naive restart on mismatch
  assign rx_next = ((match_q < len_rd_q) && (pat_cur_q == byte_q)) ? match_q + MP_W'(1) :
                   ((pat_first_q == byte_q) ? MP_W'(1) : '0);
  assign el_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign used_len = (32'(table_length_q) > TABLE_DEPTH) ? CE_W'(TABLE_DEPTH)
                                                        : CE_W'(table_length_q);
  assign entry_next = current_entry_q + CE_W'(1);

  always_comb begin
    status_o.kind     = kind_e'(kind_q);
    status_o.tx_ok    = ok_q;
    status_o.len_zero = (len_rd_q == '0);
    status_o.matched  = matched_q;
    status_o.any_rx   = any_q;
    status_o.rx_full  = (rx_next >= len_rd_q);
    status_o.tmo_hit  = (el_inc >= tmo_rd_q);
    status_o.dly_hit  = (el_inc >= dly_rd_q);
    status_o.first_in = (used_len != '0);
    status_o.next_in  = (entry_next < used_len);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      entry_q <= entry_i;
      pos_q   <= byte_position_i;
      byte_q  <= data_byte_i;
      plen_q  <= pattern_length_i;
      tmo_q   <= response_timeout_ms_i;
      dly_q   <= after_delay_ms_i;
      ok_q    <= transmit_ok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pattern && load_ent_ok && load_pos_ok) begin
      pat_mem[wr_pat_addr] <= byte_q;
    end
    if (cmd_i.wr_entry && load_ent_ok) begin
      len_mem[wr_ent_addr] <= plen_sat;
      tmo_mem[wr_ent_addr] <= tmo_q;
      dly_mem[wr_ent_addr] <= dly_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      pat_cur_q   <= pat_mem[cur_w[PA_W-1:0]];
      pat_first_q <= pat_mem[base_w[PA_W-1:0]];
      len_rd_q    <= len_mem[ent_rd];
      tmo_rd_q    <= tmo_mem[ent_rd];
      dly_rd_q    <= dly_mem[ent_rd];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q  <= '0;
      current_entry_q <= '0;
      elapsed_q       <= '0;
      match_q         <= '0;
      matched_q       <= 1'b0;
      any_q           <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        table_length_q <= cfg_wdata_i;
      end
      if (cmd_i.entry_zero) begin
        current_entry_q <= '0;
      end else if (cmd_i.entry_inc) begin
        current_entry_q <= entry_next;
      end
      if (cmd_i.entry_clear || cmd_i.clr_elapsed) begin
        elapsed_q <= '0;
      end else if (cmd_i.tick) begin
        elapsed_q <= el_inc;
      end
      if (cmd_i.entry_clear) begin
        match_q   <= '0;
        matched_q <= 1'b0;
        any_q     <= 1'b0;
      end else begin
        if (cmd_i.rx_match) begin
          match_q <= rx_next;
          if (status_o.rx_full) begin
            matched_q <= 1'b1;
          end
        end
        if (cmd_i.rx_seen) begin
          any_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ev_q <= cmd_i.ev;
      case (cmd_i.idx_sel)
        IDX_CUR:  idx_q <= 4'(current_entry_q);
        IDX_NEXT: idx_q <= 4'(entry_next);
        default:  idx_q <= 4'd0;
      endcase
    end
  end

  assign event_res_o   = ev_q;
  assign entry_index_o = idx_q;

endmodule

// ===== hw/rtl/crs_ctrl.sv =====
module crs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  crs_pkg::crs_status_t status_i,
  output crs_pkg::crs_cmd_t    cmd_o
);
  import crs_pkg::*;

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  logic   fire;
  logic   rx_allowed;

  assign fire       = (seq_q == SEQ_EXEC) && (!out_valid_q || !out_stall_i);
  assign rx_allowed = ((phase_q == PH_TX) || (phase_q == PH_REPLY)) &&
                      !status_i.matched && !status_i.len_zero;

  always_comb begin
    cmd_o         = '0;
    cmd_o.ev      = EV_NONE;
    cmd_o.idx_sel = IDX_ZERO;
    cmd_o.capture = (seq_q == SEQ_WAIT) && in_valid_i;
    cmd_o.read    = (seq_q == SEQ_READ);
    phase_d       = phase_q;

    if (fire) begin
      cmd_o.out_load = 1'b1;
      case (status_i.kind)
        KIND_LOAD_PATTERN: begin
          cmd_o.wr_pattern = 1'b1;
        end
        KIND_LOAD_TIMING: begin
          cmd_o.wr_entry = 1'b1;
        end
        KIND_START: begin
          cmd_o.entry_zero = 1'b1;
          if (status_i.first_in) begin
            cmd_o.entry_clear = 1'b1;
            cmd_o.ev          = EV_SEND;
            phase_d           = PH_TX;
          end else begin
            cmd_o.ev = EV_DONE;
            phase_d  = PH_IDLE;
          end
        end
        KIND_RX_BYTE: begin
          cmd_o.rx_seen = 1'b1;
          if (rx_allowed) begin
            cmd_o.rx_match = 1'b1;
            if (status_i.rx_full && (phase_q == PH_REPLY)) begin
              cmd_o.clr_elapsed = 1'b1;
              phase_d           = PH_AFTER;
            end
          end
        end
        KIND_TICK: begin
          if (phase_q == PH_REPLY) begin
            cmd_o.tick = 1'b1;
            if (status_i.tmo_hit) begin
              cmd_o.ev      = status_i.any_rx ? EV_ERRRSP : EV_TIMEOUT;
              cmd_o.idx_sel = IDX_CUR;
              phase_d       = PH_IDLE;
            end
          end else if (phase_q == PH_AFTER) begin
            cmd_o.tick = 1'b1;
            if (status_i.dly_hit) begin
              cmd_o.entry_inc = 1'b1;
              if (status_i.next_in) begin
                cmd_o.entry_clear = 1'b1;
                cmd_o.ev          = EV_SEND;
                cmd_o.idx_sel     = IDX_NEXT;
                phase_d           = PH_TX;
              end else begin
                cmd_o.ev = EV_DONE;
                phase_d  = PH_IDLE;
              end
            end
          end
        end
        KIND_TX_STATUS: begin
          if (phase_q == PH_TX) begin
            if (!status_i.tx_ok) begin
              cmd_o.ev      = EV_HWERR;
              cmd_o.idx_sel = IDX_CUR;
              phase_d       = PH_IDLE;
            end else begin
              cmd_o.clr_elapsed = 1'b1;
              phase_d = (status_i.len_zero || status_i.matched) ? PH_AFTER : PH_REPLY;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_WAIT: begin
        if (in_valid_i) begin
          seq_d = SEQ_READ;
        end
      end
      SEQ_READ: begin
        seq_d = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        if (fire) begin
          seq_d = SEQ_WAIT;
        end
      end
      default: begin
        seq_d = SEQ_WAIT;
      end
    endcase
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_WAIT;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (seq_q != SEQ_WAIT);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/command_response_sequencer_top.sv =====
// Steps through a loaded table of modem commands: for each entry it asks for a transmit,
// takes the transmit status, scans received bytes for the expected reply, then waits out
// the after-reply delay on millisecond ticks. Every input transaction, including loads,
// ticks and received bytes, yields exactly one result transaction (event code none when
// nothing happened). A transaction goes through capture, a registered read of the
// pattern and entry memories, and the update that loads the result register; the next
// transaction is taken while the previous result still waits, so back pressure on the
// result side only delays the update step. Configure table length only while idle.
module command_response_sequencer_top #(
  parameter int unsigned TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PATTERN_MAX = crs_pkg::PATTERN_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  entry_i,
  input  logic [3:0]  byte_position_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  pattern_length_i,
  input  logic [15:0] response_timeout_ms_i,
  input  logic [15:0] after_delay_ms_i,
  input  logic        transmit_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [3:0]  entry_index_o
);
  import crs_pkg::*;

  crs_cmd_t    cmd;
  crs_status_t status;

  crs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  crs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .kind_i                (kind_i),
    .entry_i               (entry_i),
    .byte_position_i       (byte_position_i),
    .data_byte_i           (data_byte_i),
    .pattern_length_i      (pattern_length_i),
    .response_timeout_ms_i (response_timeout_ms_i),
    .after_delay_ms_i      (after_delay_ms_i),
    .transmit_ok_i         (transmit_ok_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .event_res_o           (event_res_o),
    .entry_index_o         (entry_index_o)
  );

endmodule
